### hw/rtl/ipal_pkg.sv
// ----------------------------------------------------------------------------
// ipal_pkg
// Types, constants and helpers for the indexed palette scan-out block.
// ----------------------------------------------------------------------------
package ipal_pkg;

  localparam int unsigned DimW       = 10;
  localparam int unsigned CoordW     = 9;
  localparam int unsigned ColorW     = 8;
  localparam int unsigned FbW        = 18;
  localparam int unsigned Rgb565W    = 16;
  localparam int unsigned PalDepth   = 256;
  localparam int unsigned PalIdxW    = $clog2(PalDepth);
  localparam int unsigned ProdW      = 2 * DimW;
  localparam int unsigned CfgIdxW    = 4;

  localparam logic [DimW-1:0] MaxDim      = DimW'(512);
  localparam logic [DimW-1:0] ResetWidth  = DimW'(320);
  localparam logic [DimW-1:0] ResetHeight = DimW'(240);

  localparam logic KindPixel   = 1'b0;
  localparam logic KindPalette = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgCanvasWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgCanvasHeight = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgRotateEnable = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgFlipEnable   = CfgIdxW'(3);

  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] x_coord;
    logic [CoordW-1:0] y_coord;
    logic [ColorW-1:0] color_index;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [FbW-1:0]     fb_index;
    logic [Rgb565W-1:0] rgb565;
  } pix_out_t;

  function automatic logic [Rgb565W-1:0] pack565(input logic [3*ColorW-1:0] rgb);
    logic [ColorW-1:0] r;
    logic [ColorW-1:0] g;
    logic [ColorW-1:0] b;
    r = rgb[3*ColorW-1:2*ColorW];
    g = rgb[2*ColorW-1:ColorW];
    b = rgb[ColorW-1:0];
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

### hw/rtl/indexed_palette_rotating_scanout.sv
// ----------------------------------------------------------------------------
// indexed_palette_rotating_scanout
// Converts palette-indexed pixels into framebuffer index and RGB565 beats.
// ----------------------------------------------------------------------------
// path: an accepted pixel beat is held in the input register, then in the result register
// throughput: one beat per cycle while the sink does not stall, set by the input register and result register
// palette writes take effect for the very next accepted pixel
// reset: canvas 320x240, rotate on, flip off, palette reads as a grey ramp
// the palette needs no clearing pass: per-entry valid bits clear at reset
module indexed_palette_rotating_scanout
  import ipal_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pix_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pix_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i
);

  logic [DimW-1:0] cfg_width_q;
  logic [DimW-1:0] cfg_height_q;
  logic            cfg_rotate_q;
  logic            cfg_flip_q;

  logic    s1_valid_q;
  pix_in_t s1_q;

  logic              out_valid_q;
  logic [FbW-1:0]    fb_q;
  logic [ColorW-1:0] ci_q;
  logic [3*ColorW-1:0] rd_q;
  logic              rd_vld_q;

  logic [3*ColorW-1:0] pal_mem [PalDepth];
  logic [PalDepth-1:0] pal_vld_q;

  logic              adv2;
  logic              pal_we;
  logic              pix_ok;
  logic [DimW-1:0]   w;
  logic [DimW-1:0]   h;
  logic [DimW-1:0]   xe;
  logic [DimW-1:0]   ye;
  logic [DimW-1:0]   xf;
  logic [DimW-1:0]   yf;
  logic [DimW-1:0]   mul_a;
  logic [DimW-1:0]   mul_b;
  logic [DimW-1:0]   add_c;
  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  sum;
  logic [3*ColorW-1:0] color;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= ResetWidth;
      cfg_height_q <= ResetHeight;
      cfg_rotate_q <= 1'b1;
      cfg_flip_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgCanvasWidth:  cfg_width_q  <= cfg_data_i;
        CfgCanvasHeight: cfg_height_q <= cfg_data_i;
        CfgRotateEnable: cfg_rotate_q <= cfg_data_i[0];
        CfgFlipEnable:   cfg_flip_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv2       = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv2;
  assign pal_we     = s1_valid_q && (s1_q.kind == KindPalette) && adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_data_i;
    end
  end

  // index calculation
  always_comb begin
    w      = (cfg_width_q > MaxDim) ? MaxDim : cfg_width_q;
    h      = (cfg_height_q > MaxDim) ? MaxDim : cfg_height_q;
    xe     = {1'b0, s1_q.x_coord};
    ye     = {1'b0, s1_q.y_coord};
    pix_ok = (s1_q.kind == KindPixel) && (xe < w) && (ye < h);
    xf     = cfg_flip_q ? (w - DimW'(1) - xe) : xe;
    yf     = cfg_flip_q ? (h - DimW'(1) - ye) : ye;
    if (cfg_rotate_q) begin
      mul_a = xf;
      mul_b = h;
      add_c = h - DimW'(1) - yf;
    end else begin
      mul_a = yf;
      mul_b = w;
      add_c = xf;
    end
    prod = ProdW'(mul_a) * ProdW'(mul_b);
    sum  = prod + ProdW'(add_c);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv2) begin
      out_valid_q <= s1_valid_q && pix_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      fb_q <= sum[FbW-1:0];
      ci_q <= s1_q.color_index;
    end
  end

  // palette memory
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[s1_q.color_index[PalIdxW-1:0]] <= {s1_q.red, s1_q.green, s1_q.blue};
    end
    if (adv2) begin
      rd_q <= pal_mem[s1_q.color_index[PalIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (pal_we) begin
        pal_vld_q[s1_q.color_index[PalIdxW-1:0]] <= 1'b1;
      end
      if (adv2) begin
        rd_vld_q <= pal_vld_q[s1_q.color_index[PalIdxW-1:0]];
      end
    end
  end

  // unwritten entries read as grey
  assign color = rd_vld_q ? rd_q : {ci_q, ci_q, ci_q};

  assign out_valid_o         = out_valid_q;
  assign out_data_o.fb_index = fb_q;
  assign out_data_o.rgb565   = pack565(color);

`ifndef SYNTHESIS
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv2) |=> (s1_valid_q && $stable(s1_q)))
    else $error("held input register changed");

  a_pal_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we |=> !out_valid_q)
    else $error("palette write produced a result");

  a_pal_vld_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we |=> (pal_vld_q[$past(s1_q.color_index[PalIdxW-1:0])] == 1'b1))
    else $error("palette valid bit not set after write");
`endif

endmodule

### verif/ipal_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipal_checker
// Watches the pixel, result and register channels of the palette scan-out
// block, keeps its own copy of canvas setup and palette, predicts each
// framebuffer write and compares it against the result beats in order.
// ----------------------------------------------------------------------------
module ipal_checker
  import ipal_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  pix_in_t            in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  pix_out_t           out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  output int unsigned        err_count_o,
  output int unsigned        pending_o,
  output int unsigned        pixels_seen_o
);

  logic [DimW-1:0]     width_q;
  logic [DimW-1:0]     height_q;
  logic                rotate_q;
  logic                flip_q;
  logic [3*ColorW-1:0] palette_q [PalDepth];
  pix_out_t            fb_writes_q [$];
  pix_out_t            got_write;
  pix_out_t            want_write;
  int unsigned         err_count;
  int unsigned         pixels_seen;

  task automatic flag_error(input string what);
    $display("%0t ERROR: %s", $realtime, what);
    err_count++;
  endtask

  function automatic int unsigned clip_dim(input logic [DimW-1:0] d);
    return (d > MaxDim) ? int'(MaxDim) : int'(d);
  endfunction

  // framebuffer write for one pixel beat, 0 when it falls off the canvas
  function automatic bit convert_pixel(input pix_in_t px, output pix_out_t fb);
    int unsigned         w;
    int unsigned         h;
    int unsigned         x;
    int unsigned         y;
    int unsigned         idx;
    logic [3*ColorW-1:0] rgb;
    w  = clip_dim(width_q);
    h  = clip_dim(height_q);
    x  = px.x_coord;
    y  = px.y_coord;
    fb = '0;
    if (x >= w || y >= h) begin
      return 1'b0;
    end
    if (flip_q) begin
      x = w - 1 - x;
      y = h - 1 - y;
    end
    if (rotate_q) begin
      idx = x * h + (h - 1 - y);
    end else begin
      idx = y * w + x;
    end
    rgb         = palette_q[px.color_index];
    fb.fb_index = FbW'(idx);
    fb.rgb565   = {rgb[23:19], rgb[15:10], rgb[7:3]};
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = ResetWidth;
      height_q = ResetHeight;
      rotate_q = 1'b1;
      flip_q   = 1'b0;
      for (int i = 0; i < PalDepth; i++) begin
        palette_q[i] = {3{8'(i)}};
      end
      fb_writes_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgCanvasWidth:  width_q  = cfg_data_i;
          CfgCanvasHeight: height_q = cfg_data_i;
          CfgRotateEnable: rotate_q = cfg_data_i[0];
          CfgFlipEnable:   flip_q   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.kind == KindPalette) begin
          palette_q[in_data_i.color_index] = {in_data_i.red, in_data_i.green, in_data_i.blue};
        end else if (convert_pixel(in_data_i, want_write)) begin
          fb_writes_q.push_back(want_write);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got_write = out_data_i;
        if (fb_writes_q.size() == 0) begin
          flag_error($sformatf("beat with nothing pending: fb_index %0d rgb565 %h",
                               got_write.fb_index, got_write.rgb565));
        end else begin
          want_write = fb_writes_q.pop_front();
          if (got_write.fb_index !== want_write.fb_index) begin
            flag_error($sformatf("fb_index %0d, want %0d", got_write.fb_index,
                                 want_write.fb_index));
          end
          if (got_write.rgb565 !== want_write.rgb565) begin
            flag_error($sformatf("rgb565 %h, want %h (fb_index %0d)", got_write.rgb565,
                                 want_write.rgb565, want_write.fb_index));
          end
          pixels_seen++;
        end
      end
      pending_o <= fb_writes_q.size();
    end
    err_count_o   <= err_count;
    pixels_seen_o <= pixels_seen;
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel and palette beats into the palette scan-out block under a
// series of canvas sizes, rotate and flip settings, with bursty input and a
// stalling sink; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import ipal_pkg::*;

  localparam int unsigned NumPhases     = 10;
  localparam int unsigned BeatsPerPhase = 160;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pix_in_t            in_data;
  logic               out_valid;
  logic               out_stall;
  pix_out_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DimW-1:0]    cfg_data;

  int unsigned err_count;
  int unsigned pending;
  int unsigned pixels_seen;
  int unsigned beats_sent;
  int unsigned palette_writes;
  int unsigned canvas_setups;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_palette_rotating_scanout dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ipal_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .pixels_seen_o (pixels_seen)
  );

  function automatic pix_in_t make_pixel(input int unsigned x, y, ci);
    pix_in_t px;
    px.kind        = KindPixel;
    px.x_coord     = CoordW'(x);
    px.y_coord     = CoordW'(y);
    px.color_index = ColorW'(ci);
    px.red         = ColorW'($urandom);
    px.green       = ColorW'($urandom);
    px.blue        = ColorW'($urandom);
    return px;
  endfunction

  function automatic pix_in_t make_entry(input int unsigned ci, r, g, b);
    pix_in_t px;
    px.kind        = KindPalette;
    px.x_coord     = CoordW'($urandom);
    px.y_coord     = CoordW'($urandom);
    px.color_index = ColorW'(ci);
    px.red         = ColorW'(r);
    px.green       = ColorW'(g);
    px.blue        = ColorW'(b);
    return px;
  endfunction

  task automatic push_beat(input pix_in_t px);
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (px.kind == KindPalette) begin
      palette_writes++;
    end
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every predicted write is out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_canvas(input int unsigned w, h, input bit rot, flip);
    logic [CfgIdxW-1:0] regs [4];
    logic [DimW-1:0]    vals [4];
    regs = '{CfgCanvasWidth, CfgCanvasHeight, CfgRotateEnable, CfgFlipEnable};
    vals = '{DimW'(w), DimW'(h), DimW'(rot), DimW'(flip)};
    settle();
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    canvas_setups++;
  endtask

  task automatic directed_beat(input pix_in_t px);
    push_beat(px);
    idle_gap($urandom_range(0, 2));
  endtask

  // sink stall pattern: free, light, heavy or periodic
  initial begin : stall_gen
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    out_stall <= 1'b0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= tick[2];
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned burst_left;
    int unsigned pick;
    bit          rot;
    bit          flip;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    beats_sent     = 0;
    palette_writes = 0;
    canvas_setups  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset canvas 320x240, rotated, grey ramp palette
    directed_beat(make_pixel(0, 0, 0));
    directed_beat(make_pixel(319, 239, 255));
    directed_beat(make_pixel(319, 0, 128));
    directed_beat(make_pixel(320, 5, 1));
    directed_beat(make_pixel(5, 240, 1));
    directed_beat(make_pixel(511, 511, 255));
    directed_beat(make_entry(255, 8'hff, 8'hff, 8'hff));
    directed_beat(make_pixel(10, 10, 255));
    directed_beat(make_entry(0, 8'h07, 8'h03, 8'h07));
    directed_beat(make_pixel(1, 1, 0));
    directed_beat(make_entry(170, 8'haa, 8'h55, 8'haa));
    directed_beat(make_pixel(100, 200, 170));

    set_canvas(512, 512, 1'b0, 1'b1);
    directed_beat(make_pixel(0, 0, 170));
    directed_beat(make_pixel(511, 511, 255));
    directed_beat(make_pixel(256, 1, 7));

    // zero width drops every pixel
    set_canvas(0, 240, 1'b1, 1'b0);
    directed_beat(make_pixel(0, 0, 3));

    // oversized canvas clamps to the maximum
    set_canvas(1023, 1023, 1'b1, 1'b1);
    directed_beat(make_pixel(511, 511, 4));
    directed_beat(make_pixel(0, 0, 5));

    set_canvas(1, 1, 1'b1, 1'b1);
    directed_beat(make_pixel(0, 0, 9));
    directed_beat(make_pixel(1, 0, 9));

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       begin w = 512; h = 512; end
        1:       begin w = 1;   h = 512; end
        2:       begin w = 512; h = 1;   end
        default: begin
          w = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 512);
          h = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 512);
        end
      endcase
      if (phase < 4) begin
        rot  = phase[0];
        flip = phase[1];
      end else begin
        rot  = $urandom_range(0, 1);
        flip = $urandom_range(0, 1);
      end
      set_canvas(w, h, rot, flip);
      burst_left = $urandom_range(1, 24);
      for (int unsigned n = 0; n < BeatsPerPhase; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          push_beat(make_entry($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255)));
        end else if (pick < 25) begin
          push_beat(make_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                               $urandom_range(0, 255)));
        end else begin
          push_beat(make_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                               $urandom_range(0, 255)));
        end
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (phase % 4 != 3) begin
            idle_gap($urandom_range(0, 8));
          end
        end
      end
    end

    settle();
    $display("sent %0d beats including %0d palette writes, checked %0d framebuffer writes",
             beats_sent, palette_writes, pixels_seen);
    $display("ran %0d canvas setups: extreme, zero and oversized sizes, all rotate/flip pairs",
             canvas_setups);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ipal_pkg.sv
hw/rtl/indexed_palette_rotating_scanout.sv
verif/ipal_checker.sv
verif/tb_top.sv
